// File: hdl/rmq_pkg.sv
// Package: sizes, types and helper functions for the range minimum query engine
`default_nettype none

package rmq_pkg;

  localparam int MAX_ELEMENTS = 1024;
  localparam int LOG_LEVELS   = 11;

  localparam int VALUE_W   = 32;
  localparam int RANGE_W   = 10;
  localparam int CNT_W     = $clog2(MAX_ELEMENTS + 1);
  localparam int LVL_W     = $clog2(LOG_LEVELS);
  localparam int MEM_DEPTH = LOG_LEVELS * MAX_ELEMENTS;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int LEN_W     = RANGE_W + 1;
  localparam int TOP_W     = $clog2(LEN_W);
  localparam int CMP_W0    = (CNT_W > LOG_LEVELS) ? CNT_W : LOG_LEVELS;
  localparam int CMP_W     = ((CMP_W0 > RANGE_W) ? CMP_W0 : RANGE_W) + 1;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic        [RANGE_W-1:0] range_t;
  typedef logic        [CNT_W-1:0]   cnt_t;
  typedef logic        [LVL_W-1:0]   lvl_t;
  typedef logic        [ADDR_W-1:0]  addr_t;
  typedef logic        [LEN_W-1:0]   len_t;
  typedef logic        [TOP_W-1:0]   top_t;
  typedef logic        [CMP_W-1:0]   cmp_t;
  typedef logic                      cmd_t;

  localparam cmd_t CMD_LOAD  = 1'b0;
  localparam cmd_t CMD_QUERY = 1'b1;

  function automatic value_t min_value(input value_t a, input value_t b);
    return (a <= b) ? a : b;
  endfunction

  // table entry of window level lvl starting at position pos
  function automatic addr_t cell_addr(input lvl_t lvl, input cnt_t pos);
    return ADDR_W'(ADDR_W'(lvl) * ADDR_W'(MAX_ELEMENTS) + ADDR_W'(pos));
  endfunction

  // priority encoder: index of the highest set bit
  function automatic top_t top_bit(input len_t x);
    top_t k;
    k = '0;
    for (int i = 0; i < LEN_W; i++) begin
      if (x[i]) k = TOP_W'(i);
    end
    return k;
  endfunction

endpackage

`default_nettype wire

// File: hdl/rmq_ifs.sv
// Interfaces: load/query input channel and result channel
`default_nettype none

interface rmq_in_if;
  logic                 valid;
  logic                 ready;
  rmq_pkg::cmd_t        command;
  rmq_pkg::value_t      value;
  logic                 last_element;
  rmq_pkg::range_t      range_left;
  rmq_pkg::range_t      range_right;

  modport source (output valid, command, value, last_element, range_left, range_right,
                  input ready);
  modport sink   (input valid, command, value, last_element, range_left, range_right,
                  output ready);
endinterface

interface rmq_out_if;
  logic                 valid;
  logic                 ready;
  rmq_pkg::value_t      minimum;
  logic                 query_error;

  modport source (output valid, minimum, query_error, input ready);
  modport sink   (input valid, minimum, query_error, output ready);
endinterface

`default_nettype wire

// File: hdl/range_minimum_query_engine.sv
// Top level: sparse table range minimum query engine on one two-read-port memory
//
//   channel  | role   | transaction
//   ---------+--------+-----------------------------------------------------
//   in_ch    | sink   | load one value (command 0) or range query (command 1)
//   out_ch   | source | minimum and query_error, one per query
//
// A load is written to the table when it is accepted. A query goes through
// accept, table read and compare, and the table read is registered.
// The build after a last-marked load fills each table entry in turn: it
// reads both half windows, then writes their minimum.
// Reset clears the count and the built flag; the table needs no clearing pass.
// in_ch.ready is low during a build and a query; a query waits in its final
// cycle while an earlier result is still unaccepted on out_ch.
`default_nettype none

module range_minimum_query_engine (
  input  wire logic  clk,
  input  wire logic  rst_n,
  rmq_in_if.sink     in_ch,
  rmq_out_if.source  out_ch
);
  import rmq_pkg::*;

  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_BUILD_RD  = 3'd1;
  localparam logic [2:0] ST_BUILD_WR  = 3'd2;
  localparam logic [2:0] ST_QUERY_RD  = 3'd3;
  localparam logic [2:0] ST_QUERY_OUT = 3'd4;

  logic [2:0] state_r, state_nxt;
  cnt_t       count_r, count_nxt;
  logic       built_r, built_nxt;
  lvl_t       lvl_r, lvl_nxt;
  cnt_t       pos_r, pos_nxt;
  range_t     q_left_r, q_left_nxt;
  range_t     q_right_r, q_right_nxt;
  logic       q_err_r, q_err_nxt;
  logic       out_valid_r, out_valid_nxt;
  value_t     out_min_r, out_min_nxt;
  logic       out_err_r, out_err_nxt;

  value_t     mem [MEM_DEPTH];
  value_t     rd_a_r, rd_b_r;
  logic       mem_we, mem_re;
  addr_t      mem_wa, ra_a, ra_b;
  value_t     mem_wd;

  logic       in_acc;
  cnt_t       count_eff, half;
  cmp_t       span, next_end;
  len_t       q_len, q_second;
  top_t       q_top;
  lvl_t       q_lvl;

  assign in_ch.ready    = (state_r == ST_IDLE);
  assign in_acc         = in_ch.valid && in_ch.ready;
  assign out_ch.valid   = out_valid_r;
  assign out_ch.minimum = out_min_r;
  assign out_ch.query_error = out_err_r;

  // build geometry
  assign half     = CNT_W'(1) << (lvl_r - lvl_t'(1));
  assign span     = CMP_W'(1) << lvl_r;
  assign next_end = CMP_W'(pos_r) + CMP_W'(1) + span;

  // query geometry: two windows of level k covering [left, right]
  always_comb begin
    q_len    = LEN_W'(q_right_r) - LEN_W'(q_left_r) + LEN_W'(1);
    q_top    = top_bit(q_len);
    if (int'(q_top) > LOG_LEVELS - 1) q_lvl = LVL_W'(LOG_LEVELS - 1);
    else                              q_lvl = LVL_W'(q_top);
    q_second = LEN_W'(q_right_r) + LEN_W'(1) - (LEN_W'(1) << q_lvl);
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    built_nxt     = built_r;
    lvl_nxt       = lvl_r;
    pos_nxt       = pos_r;
    q_left_nxt    = q_left_r;
    q_right_nxt   = q_right_r;
    q_err_nxt     = q_err_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_min_nxt   = out_min_r;
    out_err_nxt   = out_err_r;
    mem_we        = 1'b0;
    mem_wa        = cell_addr(lvl_r, pos_r);
    mem_wd        = min_value(rd_a_r, rd_b_r);
    mem_re        = 1'b0;
    ra_a          = cell_addr(lvl_r - lvl_t'(1), pos_r);
    ra_b          = cell_addr(lvl_r - lvl_t'(1), pos_r + half);
    count_eff     = built_r ? '0 : count_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_ch.command)
            CMD_LOAD: begin
              built_nxt = 1'b0;
              count_nxt = count_eff;
              if (count_eff < CNT_W'(MAX_ELEMENTS)) begin
                mem_we    = 1'b1;
                mem_wa    = cell_addr('0, count_eff);
                mem_wd    = in_ch.value;
                count_nxt = count_eff + cnt_t'(1);
              end
              if (in_ch.last_element) begin
                lvl_nxt = lvl_t'(1);
                pos_nxt = '0;
                if (count_nxt >= cnt_t'(2)) state_nxt = ST_BUILD_RD;
                else                        built_nxt = 1'b1;
              end
            end
            CMD_QUERY: begin
              q_left_nxt  = in_ch.range_left;
              q_right_nxt = in_ch.range_right;
              q_err_nxt   = !built_r || (in_ch.range_left > in_ch.range_right) ||
                            (CMP_W'(in_ch.range_right) >= CMP_W'(count_r));
              state_nxt   = ST_QUERY_RD;
            end
            default: ;
          endcase
        end
      end
      // reads and writes alternate, so a read never meets a write in flight
      ST_BUILD_RD: begin
        mem_re    = 1'b1;
        state_nxt = ST_BUILD_WR;
      end
      ST_BUILD_WR: begin
        mem_we = 1'b1;
        priority if (next_end <= CMP_W'(count_r)) begin
          pos_nxt   = pos_r + cnt_t'(1);
          state_nxt = ST_BUILD_RD;
        end else if ((lvl_r != LVL_W'(LOG_LEVELS - 1)) &&
                     ((span << 1) <= CMP_W'(count_r))) begin
          lvl_nxt   = lvl_r + lvl_t'(1);
          pos_nxt   = '0;
          state_nxt = ST_BUILD_RD;
        end else begin
          built_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_QUERY_RD: begin
        mem_re    = !q_err_r;
        ra_a      = cell_addr(q_lvl, CNT_W'(q_left_r));
        ra_b      = cell_addr(q_lvl, CNT_W'(q_second));
        state_nxt = ST_QUERY_OUT;
      end
      ST_QUERY_OUT: begin
        // hold until the output register is free
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_min_nxt   = q_err_r ? '0 : min_value(rd_a_r, rd_b_r);
          out_err_nxt   = q_err_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) begin
      rd_a_r <= mem[ra_a];
      rd_b_r <= mem[ra_b];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      built_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      built_r     <= built_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lvl_r     <= lvl_nxt;
    pos_r     <= pos_nxt;
    q_left_r  <= q_left_nxt;
    q_right_r <= q_right_nxt;
    q_err_r   <= q_err_nxt;
    out_min_r <= out_min_nxt;
    out_err_r <= out_err_nxt;
  end

`ifndef SYNTHESIS
  a_build_in_set: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_BUILD_RD) |-> (CMP_W'(pos_r) + span <= CMP_W'(count_r)))
    else $error("build window runs past the loaded set");

  a_built_idle: assert property (@(posedge clk) disable iff (!rst_n)
    built_r |-> (state_r != ST_BUILD_RD && state_r != ST_BUILD_WR))
    else $error("table marked built while a build is running");

  a_result_from_query: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_QUERY_OUT)
    else $error("result raised without a query");

  a_error_min_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_err_r) |-> (out_min_r == '0))
    else $error("refused query carries a non-zero minimum");
`endif

endmodule

`default_nettype wire

// File: tb/tb.sv
// Testbench: loads and range queries against a sparse-table predictor, checking every result
module tb;
  import rmq_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_ITEMS = 650;
  localparam value_t VALUE_MAX = 32'sh7FFF_FFFF;
  localparam value_t VALUE_MIN = 32'sh8000_0000;

  typedef struct packed {
    value_t minimum;
    logic   query_error;
  } range_result_t;

  logic clk;
  logic rst_n;

  rmq_in_if  in_ch ();
  rmq_out_if out_ch ();

  range_minimum_query_engine i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // predicted block state
  value_t window_min [LOG_LEVELS][MAX_ELEMENTS];
  int     set_size;
  bit     set_built;

  range_result_t awaited_minima [$];
  range_result_t oldest;
  int            mismatch_count;
  int unsigned   cycle_count;
  int            items_sent;
  int            burst_left;
  bit            gaps_enabled;
  int            stall_mode = 0;
  int            stall_span = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic value_t lesser(input value_t a, input value_t b);
    return (a <= b) ? a : b;
  endfunction

  function automatic int highest_set_bit(input int x);
    int k;
    k = 0;
    for (int i = 0; i < 32; i++) begin
      if (x[i]) k = i;
    end
    return k;
  endfunction

  function automatic void rebuild_windows();
    int half;
    for (int lvl = 1; lvl < LOG_LEVELS && (1 << lvl) <= set_size; lvl++) begin
      half = 1 << (lvl - 1);
      for (int i = 0; i + (1 << lvl) <= set_size; i++)
        window_min[lvl][i] = lesser(window_min[lvl-1][i], window_min[lvl-1][i+half]);
    end
    set_built = 1'b1;
  endfunction

  function automatic void predict_item(input cmd_t command, input value_t value,
                                       input logic last, input range_t left,
                                       input range_t right);
    int            lvl;
    int            second;
    range_result_t res;
    if (command == CMD_LOAD) begin
      // a load after the build starts a new set
      if (set_built) begin
        set_size  = 0;
        set_built = 1'b0;
      end
      if (set_size < MAX_ELEMENTS) begin
        window_min[0][set_size] = value;
        set_size++;
      end
      if (last) rebuild_windows();
    end else begin
      if (!set_built || left > right || int'(right) >= set_size) begin
        res.minimum     = '0;
        res.query_error = 1'b1;
      end else begin
        lvl = highest_set_bit(int'(right) - int'(left) + 1);
        if (lvl > LOG_LEVELS - 1) lvl = LOG_LEVELS - 1;
        second = int'(right) + 1 - (1 << lvl);
        res.minimum     = lesser(window_min[lvl][left], window_min[lvl][second]);
        res.query_error = 1'b0;
      end
      awaited_minima.push_back(res);
    end
  endfunction

  function automatic value_t pick_value();
    int offset;
    offset = $urandom_range(0, 20);
    case ($urandom_range(0, 9))
      0:       return VALUE_MAX;
      1:       return VALUE_MIN;
      2:       return value_t'(offset - 10);
      default: return value_t'($urandom);
    endcase
  endfunction

  function automatic range_t any_pos();
    return range_t'($urandom_range(0, 1023));
  endfunction

  // drive at the falling edge, hold until the transaction is taken
  task automatic send_item(input cmd_t command, input value_t value, input logic last,
                           input range_t left, input range_t right);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap        = gaps_enabled ? $urandom_range(0, 5) : 0;
      burst_left = $urandom_range(1, 16);
      if (gap != 0) begin
        in_ch.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_ch.command      = command;
    in_ch.value        = value;
    in_ch.last_element = last;
    in_ch.range_left   = left;
    in_ch.range_right  = right;
    in_ch.valid        = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    predict_item(command, value, last, left, right);
    items_sent++;
  endtask

  task automatic load_set(input int n, input bit finish);
    for (int i = 0; i < n; i++)
      send_item(CMD_LOAD, pick_value(), finish && (i == n - 1), any_pos(), any_pos());
  endtask

  task automatic query(input range_t left, input range_t right);
    send_item(CMD_QUERY, value_t'($urandom), 1'($urandom_range(0, 1)), left, right);
  endtask

  task automatic random_query(input int n);
    int l;
    int r;
    int kind;
    kind = $urandom_range(0, 11);
    if (kind == 0) begin
      l = $urandom_range(1, 1023);
      r = $urandom_range(0, l - 1);
    end else if (kind == 1 && n < 1024) begin
      r = $urandom_range(n, 1023);
      l = $urandom_range(0, r);
    end else if (kind == 2) begin
      l = any_pos();
      r = any_pos();
    end else if (kind == 3) begin
      l = 0;
      r = n - 1;
    end else begin
      r = $urandom_range(0, n - 1);
      l = $urandom_range(0, r);
    end
    query(range_t'(l), range_t'(r));
  endtask

  task automatic wait_results_drained();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (awaited_minima.size() != 0) @(posedge clk);
  endtask

  task automatic test_query_before_build();
    query(0, 0);
    query(1023, 1023);
  endtask

  task automatic test_extremes();
    send_item(CMD_LOAD, VALUE_MAX, 1'b0, any_pos(), any_pos());
    send_item(CMD_LOAD, VALUE_MIN, 1'b0, any_pos(), any_pos());
    send_item(CMD_LOAD, 32'sd0, 1'b0, any_pos(), any_pos());
    send_item(CMD_LOAD, -32'sd1, 1'b0, any_pos(), any_pos());
    send_item(CMD_LOAD, 32'sd1, 1'b1, any_pos(), any_pos());
    query(0, 0);
    query(0, 1);
    query(0, 4);
    query(2, 4);
    query(3, 4);
    query(4, 4);
  endtask

  task automatic test_refusals();
    query(3, 2);
    query(0, 5);
    query(1023, 1023);
    query(0, 1023);
  endtask

  task automatic test_new_set();
    load_set(1, 1'b1);
    query(0, 0);
    query(0, 1);
    // unfinished set: queries are refused until the build
    load_set(2, 1'b0);
    query(0, 1);
    load_set(1, 1'b1);
    query(0, 2);
    wait_results_drained();
  endtask

  task automatic test_random();
    int start;
    int n;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      gaps_enabled = ($urandom_range(0, 3) != 0);
      n = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 40) : $urandom_range(41, 260);
      if (n > 1 && $urandom_range(0, 7) == 0) begin
        load_set(n / 2, 1'b0);
        query(any_pos(), any_pos());
        load_set(n - n / 2, 1'b1);
      end else begin
        load_set(n, 1'b1);
      end
      repeat ($urandom_range(3, 25)) random_query(n);
      if ($urandom_range(0, 3) == 0) wait_results_drained();
    end
    gaps_enabled = 1'b1;
  endtask

  task automatic test_capacity();
    // values past capacity are the most negative, so keeping one shows up at once
    for (int i = 0; i < MAX_ELEMENTS + 6; i++)
      send_item(CMD_LOAD, (i < MAX_ELEMENTS) ? pick_value() : VALUE_MIN,
                i == MAX_ELEMENTS + 5, any_pos(), any_pos());
    query(0, 1023);
    query(1, 1023);
    query(0, 511);
    query(1023, 1023);
    repeat (20) random_query(MAX_ELEMENTS);
  endtask

  always @(negedge clk) begin
    if (stall_span == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_span <= $urandom_range(20, 150);
    end else begin
      stall_span <= stall_span - 1;
    end
    case (stall_mode)
      0:       out_ch.ready <= 1'b1;
      1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
      default: out_ch.ready <= ($urandom_range(0, 5) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (awaited_minima.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: minimum %0d query_error %0b",
                   out_ch.minimum, out_ch.query_error);
      end else begin
        oldest = awaited_minima.pop_front();
        if (out_ch.minimum !== oldest.minimum || out_ch.query_error !== oldest.query_error) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result mismatch: expected minimum %0d query_error %0b, got %0d %0b",
                     oldest.minimum, oldest.query_error, out_ch.minimum, out_ch.query_error);
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL range_minimum_query_engine");
    $finish;
  end

  initial begin
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.command      = CMD_LOAD;
    in_ch.value        = '0;
    in_ch.last_element = 1'b0;
    in_ch.range_left   = '0;
    in_ch.range_right  = '0;
    out_ch.ready       = 1'b1;
    mismatch_count     = 0;
    items_sent         = 0;
    burst_left         = 0;
    gaps_enabled       = 1'b1;
    set_size           = 0;
    set_built          = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_query_before_build();
    test_extremes();
    test_refusals();
    test_new_set();
    test_random();
    test_capacity();

    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && awaited_minima.size() == 0)
      $display("PASS range_minimum_query_engine");
    else
      $display("FAIL range_minimum_query_engine");
    $finish;
  end

endmodule

// File: range_minimum_query_engine.f
hdl/rmq_pkg.sv
hdl/rmq_ifs.sv
hdl/range_minimum_query_engine.sv
tb/tb.sv
